// ===== design/bek_pkg.sv =====
// Package: types, codes and character helpers for the body end keyword scanner.
`timescale 1ns / 1ps

package bek_pkg;

	localparam int unsigned PosW    = 32;
	localparam int unsigned LenW    = 4;
	localparam int unsigned StatusW = 3;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned OutDataW = 40;

	localparam logic [LenW-1:0] LenMax  = 4'd15;
	localparam logic [LenW-1:0] EndLen  = 4'd3;
	localparam logic [LenW-1:0] FuncLen = 4'd8;

	localparam logic [ByteW-1:0] ChSlash = 8'h2F;
	localparam logic [ByteW-1:0] ChStar  = 8'h2A;
	localparam logic [ByteW-1:0] ChQuote = 8'h27;
	localparam logic [ByteW-1:0] ChLf    = 8'h0A;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_BLOCK_STAR,
		MODE_STRING,
		MODE_STRING_QUOTE,
		MODE_IDENT
	} mode_t;

	typedef enum logic [StatusW-1:0] {
		ST_END_FOUND       = 3'd0,
		ST_OPEN_COMMENT    = 3'd1,
		ST_OPEN_STRING     = 3'd2,
		ST_FUNCTION_INSIDE = 3'd3,
		ST_NO_END          = 3'd4
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] source_byte;
		logic             first_byte;
		logic             last_byte;
	} in_item_t;

	typedef struct packed {
		logic            valid;
		status_t         status;
		logic [PosW-1:0] position;
	} scan_res_t;

	function automatic logic is_ident_start(input logic [ByteW-1:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
	endfunction

	function automatic logic is_ident_cont(input logic [ByteW-1:0] b);
		return is_ident_start(b) || (b >= 8'h30 && b <= 8'h39);
	endfunction

	// "end"
	function automatic logic [ByteW-1:0] kw_end_char(input logic [1:0] i);
		logic [ByteW-1:0] c;
		unique case (i)
			2'd0: c = 8'h65;
			2'd1: c = 8'h6E;
			2'd2: c = 8'h64;
			default: c = 8'h65;
		endcase
		return c;
	endfunction

	// "function"
	function automatic logic [ByteW-1:0] kw_func_char(input logic [2:0] i);
		logic [ByteW-1:0] c;
		unique case (i)
			3'd0: c = 8'h66;
			3'd1: c = 8'h75;
			3'd2: c = 8'h6E;
			3'd3: c = 8'h63;
			3'd4: c = 8'h74;
			3'd5: c = 8'h69;
			3'd6: c = 8'h6F;
			default: c = 8'h6E;
		endcase
		return c;
	endfunction

endpackage

// ===== design/body_end_keyword_scanner_core.sv =====
// Top level: body end keyword scanner with input register, scan logic and result register.
`timescale 1ns / 1ps

// Takes one source byte per cycle and sustains one byte per clock unless the result register
// is stalled; a byte reaches the scan logic from the input register and any result it causes
// is loaded into the output register when that byte advances. The lexer state is a single
// register set updated once per byte, which sets the rate. Each scan, begun by a transaction
// with tuser set, yields exactly one result transaction; bytes after it are dropped until the
// next first byte. base_offset, written through cfg_wr_en, is added to every reported
// position; the user must write it only while the block is idle: the block does not enforce it.
module body_end_keyword_scanner_core import bek_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [ByteW-1:0]    s_axis_tdata,  // [7:0] source_byte
	input  logic [0:0]          s_axis_tuser,  // [0] first_byte
	input  logic                s_axis_tlast,  // last_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,  // [2:0] status, [34:3] position, [39:35] zero
	input  logic                cfg_wr_en,
	input  logic [PosW-1:0]     cfg_wr_data    // base_offset
);

	logic            valid_s1;
	in_item_t        item_s1;
	in_item_t        in_item;
	logic            advance;
	scan_res_t       res;
	logic [PosW-1:0] base_offset_q;
	logic            out_valid_q;
	status_t         out_status_q;
	logic [PosW-1:0] out_pos_q;

	assign in_item.source_byte = s_axis_tdata;
	assign in_item.first_byte  = s_axis_tuser[0];
	assign in_item.last_byte   = s_axis_tlast;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	bek_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bek_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.base_offset (base_offset_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_offset_q <= '0;
		end else if (cfg_wr_en) begin
			base_offset_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_status_q <= res.status;
			out_pos_q    <= res.position;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutDataW - PosW - StatusW){1'b0}}, out_pos_q, out_status_q};

endmodule

// ===== design/bek_in_stage.sv =====
// Input register stage: holds one accepted byte transaction until the scanner takes it.
`timescale 1ns / 1ps

module bek_in_stage import bek_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic vld_s1;

	assign in_ready = !vld_s1 || advance;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/bek_scan.sv =====
// Lexer state and per-byte scan logic; yields at most one result per byte.
`timescale 1ns / 1ps

module bek_scan import bek_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  in_item_t        item,
	input  logic [PosW-1:0] base_offset,
	output scan_res_t       res
);

	mode_t           mode_q, mode_d;
	logic [PosW-1:0] pos_q, pos_d;
	logic [PosW-1:0] ts_q, ts_d;
	logic [LenW-1:0] len_q, len_d;
	logic            em_q, em_d;
	logic            fm_q, fm_d;
	logic            done_q, done_d;

	logic [ByteW-1:0] b;
	logic [PosW-1:0]  p;
	logic             hit;
	status_t          hit_status;
	logic             use_base;
	logic             plain;

	always_comb begin
		b          = item.source_byte;
		mode_d     = mode_q;
		pos_d      = pos_q;
		ts_d       = ts_q;
		len_d      = len_q;
		em_d       = em_q;
		fm_d       = fm_q;
		done_d     = done_q;
		hit        = 1'b0;
		hit_status = ST_NO_END;
		use_base   = 1'b0;
		plain      = 1'b0;
		p          = pos_q;

		if (item.first_byte) begin
			mode_d = MODE_NORMAL;
			pos_d  = '0;
			ts_d   = '0;
			len_d  = '0;
			em_d   = 1'b1;
			fm_d   = 1'b1;
			done_d = 1'b0;
		end

		if (!done_d) begin
			p     = pos_d;
			pos_d = pos_d + 1'b1;

			unique case (mode_d)
				MODE_SLASH: begin
					if (b == ChSlash) begin
						mode_d = MODE_LINE;
					end else if (b == ChStar) begin
						mode_d = MODE_BLOCK;
					end else begin
						plain = 1'b1;
					end
				end
				MODE_LINE: begin
					if (b == ChLf) begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_BLOCK: begin
					if (b == ChStar) begin
						mode_d = MODE_BLOCK_STAR;
					end
				end
				MODE_BLOCK_STAR: begin
					if (b == ChSlash) begin
						mode_d = MODE_NORMAL;
					end else if (b != ChStar) begin
						mode_d = MODE_BLOCK;
					end
				end
				MODE_STRING: begin
					if (b == ChQuote) begin
						mode_d = MODE_STRING_QUOTE;
					end
				end
				MODE_STRING_QUOTE: begin
					if (b == ChQuote) begin
						mode_d = MODE_STRING;
					end else begin
						plain = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_ident_cont(b)) begin
						em_d = em_d && (len_d < EndLen) && (b == kw_end_char(len_d[1:0]));
						fm_d = fm_d && (len_d < FuncLen) && (b == kw_func_char(len_d[2:0]));
						if (len_d < LenMax) begin
							len_d = len_d + 1'b1;
						end
					end else if (len_d == EndLen && em_d) begin
						hit        = 1'b1;
						hit_status = ST_END_FOUND;
					end else if (len_d == FuncLen && fm_d) begin
						hit        = 1'b1;
						hit_status = ST_FUNCTION_INSIDE;
					end else begin
						plain = 1'b1;
					end
				end
				default: begin
					plain = 1'b1;
				end
			endcase

			// ordinary byte scanned in normal mode
			if (plain) begin
				mode_d = MODE_NORMAL;
				if (b == ChSlash) begin
					mode_d = MODE_SLASH;
					ts_d   = p;
				end else if (b == ChQuote) begin
					mode_d = MODE_STRING;
					ts_d   = p;
				end else if (is_ident_start(b)) begin
					mode_d = MODE_IDENT;
					ts_d   = p;
					len_d  = 4'd1;
					em_d   = (b == kw_end_char(2'd0));
					fm_d   = (b == kw_func_char(3'd0));
				end
			end

			if (!hit && item.last_byte) begin
				hit = 1'b1;
				priority case (mode_d)
					MODE_BLOCK, MODE_BLOCK_STAR: hit_status = ST_OPEN_COMMENT;
					MODE_STRING:                 hit_status = ST_OPEN_STRING;
					MODE_IDENT: begin
						if (len_d == EndLen && em_d) begin
							hit_status = ST_END_FOUND;
						end else if (len_d == FuncLen && fm_d) begin
							hit_status = ST_FUNCTION_INSIDE;
						end else begin
							hit_status = ST_NO_END;
							use_base   = 1'b1;
						end
					end
					default: begin
						hit_status = ST_NO_END;
						use_base   = 1'b1;
					end
				endcase
			end

			if (hit) begin
				done_d = 1'b1;
			end
		end

		res.valid    = advance && hit;
		res.status   = hit_status;
		res.position = use_base ? base_offset : base_offset + ts_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			pos_q  <= '0;
			ts_q   <= '0;
			len_q  <= '0;
			em_q   <= 1'b1;
			fm_q   <= 1'b1;
			done_q <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			ts_q   <= ts_d;
			len_q  <= len_d;
			em_q   <= em_d;
			fm_q   <= fm_d;
			done_q <= done_d;
		end
	end

endmodule

// ===== design/bek_checker.sv =====
// Port-level checker for the body end keyword scanner, bound to the top level.
`timescale 1ns / 1ps

module bek_checker import bek_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata
);

	// an empty result register never back-pressures the input
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] <= ST_NO_END))
		else $error("illegal status code");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:PosW+StatusW] == '0))
		else $error("tdata padding not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result transaction changed");

endmodule

bind body_end_keyword_scanner_core bek_checker u_bek_checker (.*);
